### hdl/tnb_pkg.sv
// Shared types, constants and helpers of the tanh neuron training unit.
package tnb_pkg;

	localparam int INPUT_COUNT_DEF = 16;
	localparam int TANH_DEPTH_DEF  = 1024;

	localparam int ACT_W   = 3;
	localparam int IDX_W   = 4;
	localparam int VAL_W   = 16;
	localparam int KIND_W  = 2;
	localparam int CFG_W   = 13;
	localparam int CFG_IDX_W = 1;
	localparam int ACC_W   = 40;

	localparam logic [CFG_W-1:0] LEARN_RATE_RST = 13'd614;
	localparam logic [CFG_W-1:0] MOMENTUM_RST   = 13'd2048;

	localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM   = 1'd1;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD = 3'd0,
		ACT_FWD  = 3'd1,
		ACT_OGR  = 3'd2,
		ACT_HID  = 3'd3,
		ACT_UPD  = 3'd4
	} action_t;

	localparam logic [KIND_W-1:0] KIND_ACT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GRAD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WGT  = 2'd2;

	typedef struct packed {
		logic                    clip;
		logic signed [VAL_W-1:0] val;
	} sat_t;

	// clip a wide signed value to Q3.12
	function automatic sat_t sat16(input logic signed [47:0] v);
		sat_t s;
		if (v > 48'sd32767) begin
			s.clip = 1'b1;
			s.val  = 16'sh7fff;
		end else if (v < -48'sd32768) begin
			s.clip = 1'b1;
			s.val  = -16'sh8000;
		end else begin
			s.clip = 1'b0;
			s.val  = v[VAL_W-1:0];
		end
		return s;
	endfunction

endpackage

### hdl/tnb_if.sv
// Valid/ready channels for items in and results out.
interface tnb_in_if;
	import tnb_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [ACT_W-1:0]        action;
	logic [IDX_W-1:0]        element_index;
	logic signed [VAL_W-1:0] value_a;
	logic signed [VAL_W-1:0] value_b;
	logic                    last;

	modport source (output valid, action, element_index, value_a, value_b, last, input ready);
	modport sink (input valid, action, element_index, value_a, value_b, last, output ready);
endinterface

interface tnb_out_if;
	import tnb_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] result_value;
	logic [KIND_W-1:0]       result_kind;
	logic                    saturated;

	modport source (output valid, result_value, result_kind, saturated, input ready);
	modport sink (input valid, result_value, result_kind, saturated, output ready);
endinterface

### hdl/tnb_ram.sv
// Generic simple dual-port RAM, one write port, registered read.
module tnb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### hdl/tnb_tanh_rom.sv
// Tanh lookup ROM, entry k = tanh(8k/DEPTH) in unsigned Q1.12, registered read.
module tnb_tanh_rom #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	output logic [12:0]              data
);
	typedef logic [12:0] lut_t [DEPTH];

	localparam logic [63:0] HSTEP = (64'd16 << 30) / DEPTH;

	// shift-subtract divide, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], num[i]};
			if (r >= {1'b0, den}) begin
				r    = r - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// t = e^(-2x) in Q0.30 stepped by a series-built ratio
	function automatic lut_t build_lut();
		lut_t        lut;
		logic [63:0] one;
		logic [63:0] term;
		logic [63:0] t;
		logic [63:0] r;
		one  = 64'd1 << 30;
		r    = one;
		term = one;
		t    = one;
		for (int n = 1; n <= 10; n++) begin
			term = udiv64((term * HSTEP) >> 30, 64'(n));
			if (n[0]) begin
				r = r - term;
			end else begin
				r = r + term;
			end
		end
		for (int k = 0; k < DEPTH; k++) begin
			lut[k] = 13'(udiv64((one - t) * 64'd8192 + (one + t), (one + t) << 1));
			t = (t * r + (one >> 1)) >> 30;
		end
		return lut;
	endfunction

	localparam lut_t TANH_LUT = build_lut();

	always_ff @(posedge clk) begin
		data <= TANH_LUT[addr];
	end
endmodule

### hdl/tanh_neuron_backprop_unit.sv
// Steps per item: a load only writes; the rest run MUL1, then: forward or hidden term without
// last ACC; output gradient FIN; hidden last ACC, MUL2, FIN; update MUL2, DLT, FIN; forward last
// ACC, ABS, TIDX, TROM (the registered tanh ROM read), FIN. Result leaves the output register
// the cycle after its final step; one item is in work at a time, the next is taken while the
// result waits. Reset is immediate: weights and momenta read as zero through per-entry valid
// bits; accumulator, activation, gradient and other registers return to their defaults.
module tanh_neuron_backprop_unit #(
	parameter int INPUT_COUNT      = tnb_pkg::INPUT_COUNT_DEF,
	parameter int TANH_TABLE_DEPTH = tnb_pkg::TANH_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tnb_in_if.sink                          item,
	tnb_out_if.source                       result,
	input  logic                            cfg_we,
	input  logic [tnb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tnb_pkg::CFG_W-1:0]       cfg_data
);
	import tnb_pkg::*;

	localparam int AW  = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
	localparam int IXW = (AW > IDX_W) ? AW : IDX_W;
	localparam int TAW = $clog2(TANH_TABLE_DEPTH);
	localparam int PW  = 28 + TAW + 1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_MUL1 = 9'b000000010,
		ST_ACC  = 9'b000000100,
		ST_ABS  = 9'b000001000,
		ST_TIDX = 9'b000010000,
		ST_TROM = 9'b000100000,
		ST_MUL2 = 9'b001000000,
		ST_DLT  = 9'b010000000,
		ST_FIN  = 9'b100000000
	} state_t;

	state_t state_q;

	// item capture
	action_t                 act_q;
	logic                    ok_q;
	logic                    last_q;
	logic                    vld_q;
	logic signed [VAL_W-1:0] a_q;
	logic signed [VAL_W-1:0] b_q;
	logic [AW-1:0]           addr_q;

	logic [CFG_W-1:0] lr_q;
	logic [CFG_W-1:0] mo_q;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [VAL_W-1:0] out_act_q;
	logic signed [VAL_W-1:0] grad_q;
	logic signed [31:0]      sq_q;
	logic [INPUT_COUNT-1:0]  vld_bits_q;

	logic signed [36:0] p1_s1;
	logic signed [29:0] p2_s1;
	logic signed [40:0] pl_s2;
	logic signed [39:0] ph_s2;
	logic signed [45:0] p3_s2;

	logic [26:0]         mag_q;
	logic                hi_q;
	logic                neg_q;
	logic [TAW-1:0]      tidx_q;
	logic                big_q;
	logic signed [VAL_W-1:0] delta_q;
	logic                dclip_q;

	logic                    res_valid_q;
	logic signed [VAL_W-1:0] res_val_q;
	logic [KIND_W-1:0]       res_kind_q;
	logic                    res_sat_q;

	// RAM and ROM ports
	logic [VAL_W-1:0] w_raw;
	logic [VAL_W-1:0] m_raw;
	logic [12:0]      rom_data;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [VAL_W-1:0] w_wdata;
	logic [VAL_W-1:0] m_wdata;

	logic             accept;
	logic             fin_go;
	action_t          act_in;
	logic             ok_in;
	logic [IXW-1:0]   idx_w;
	logic [AW-1:0]    item_addr;

	logic signed [VAL_W-1:0] w_rd;
	logic signed [VAL_W-1:0] m_rd;
	logic signed [19:0]      deriv;
	logic signed [16:0]      diff;
	logic signed [31:0]      prod_aw;
	logic signed [31:0]      prod_ab;
	logic signed [31:0]      prod_ag;
	logic signed [36:0]      prod_og;
	logic signed [29:0]      prod_mo;
	logic signed [13:0]      lr_s;
	logic signed [13:0]      mo_s;
	logic signed [20:0]      acc_lo;
	logic signed [19:0]      acc_hi;
	logic [ACC_W-1:0]        acc_mag;
	logic [PW-1:0]           tprod;
	logic [TAW+1:0]          tidx_full;
	logic signed [59:0]      hid_total;
	logic signed [46:0]      upd_sum;
	logic signed [16:0]      new_w;
	logic signed [VAL_W-1:0] tanh_y;
	sat_t                    s_og;
	sat_t                    s_hid;
	sat_t                    s_dlt;
	sat_t                    s_w;
	logic signed [VAL_W-1:0] fin_val;
	logic [KIND_W-1:0]       fin_kind;
	logic                    fin_sat;

	assign act_in    = action_t'(item.action);
	assign ok_in     = int'(item.element_index) < INPUT_COUNT;
	assign idx_w     = IXW'(item.element_index);
	assign item_addr = idx_w[AW-1:0];

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign fin_go     = (state_q == ST_FIN) && (!res_valid_q || result.ready);

	assign result.valid        = res_valid_q;
	assign result.result_value = res_val_q;
	assign result.result_kind  = res_kind_q;
	assign result.saturated    = res_sat_q;

	// loads write in the transfer cycle, updates in their final step
	assign mem_we    = (accept && act_in == ACT_LOAD && ok_in) || (fin_go && act_q == ACT_UPD);
	assign mem_waddr = (state_q == ST_IDLE) ? item_addr : addr_q;
	assign w_wdata   = (state_q == ST_IDLE) ? item.value_a : s_w.val;
	assign m_wdata   = (state_q == ST_IDLE) ? '0 : delta_q;

	tnb_ram #(.WIDTH(VAL_W), .DEPTH(INPUT_COUNT)) u_weight_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (w_wdata),
		.re    (accept),
		.raddr (item_addr),
		.rdata (w_raw)
	);

	tnb_ram #(.WIDTH(VAL_W), .DEPTH(INPUT_COUNT)) u_momentum_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (m_wdata),
		.re    (accept),
		.raddr (item_addr),
		.rdata (m_raw)
	);

	tnb_tanh_rom #(.DEPTH(TANH_TABLE_DEPTH)) u_tanh_rom (
		.clk  (clk),
		.addr (tidx_q),
		.data (rom_data)
	);

	// datapath
	always_comb begin
		w_rd    = (vld_q && ok_q) ? signed'(w_raw) : '0;
		m_rd    = (vld_q && ok_q) ? signed'(m_raw) : '0;
		deriv   = 20'sd4096 - 20'((sq_q + 32'sd2048) >>> 12);
		diff    = a_q - out_act_q;
		prod_aw = a_q * w_rd;
		prod_ab = a_q * b_q;
		prod_ag = a_q * grad_q;
		prod_og = diff * deriv;
		lr_s    = signed'({1'b0, lr_q});
		mo_s    = signed'({1'b0, mo_q});
		prod_mo = mo_s * m_rd;
		acc_lo  = signed'({1'b0, acc_q[19:0]});
		acc_hi  = acc_q[ACC_W-1:20];
		acc_mag = acc_q[ACC_W-1] ? unsigned'(-acc_q) : unsigned'(acc_q);
		tprod   = PW'(mag_q) * PW'(TANH_TABLE_DEPTH) + (PW'(1) << 26);
		tidx_full = tprod[PW-1:27];

		hid_total = (60'(ph_s2) <<< 20) + 60'(pl_s2);
		upd_sum   = 47'(p3_s2) + (47'(p2_s1) <<< 12);
		s_og  = sat16(48'((p1_s1 + 37'sd2048) >>> 12));
		s_hid = sat16(48'((hid_total + 60'sd8388608) >>> 24));
		s_dlt = sat16(48'((upd_sum + 47'sd8388608) >>> 24));
		new_w = w_rd + delta_q;
		s_w   = sat16(48'(new_w));

		tanh_y = big_q ? 16'sd4096 : signed'(16'(rom_data));

		unique case (act_q)
			ACT_FWD: begin
				fin_val  = neg_q ? -tanh_y : tanh_y;
				fin_kind = KIND_ACT;
				fin_sat  = 1'b0;
			end
			ACT_OGR: begin
				fin_val  = s_og.val;
				fin_kind = KIND_GRAD;
				fin_sat  = s_og.clip;
			end
			ACT_HID: begin
				fin_val  = s_hid.val;
				fin_kind = KIND_GRAD;
				fin_sat  = s_hid.clip;
			end
			ACT_UPD: begin
				fin_val  = s_w.val;
				fin_kind = KIND_WGT;
				fin_sat  = s_w.clip || dclip_q;
			end
			default: begin
				fin_val  = '0;
				fin_kind = KIND_ACT;
				fin_sat  = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (act_in == ACT_FWD || act_in == ACT_OGR || act_in == ACT_HID)
							state_q <= ST_MUL1;
						else if (act_in == ACT_UPD && ok_in)
							state_q <= ST_MUL1;
						else
							state_q <= ST_IDLE;
					end
				end
				ST_MUL1: begin
					priority if (act_q == ACT_OGR) state_q <= ST_FIN;
					else if (act_q == ACT_UPD)     state_q <= ST_MUL2;
					else                           state_q <= ST_ACC;
				end
				ST_ACC: begin
					priority if (!last_q)      state_q <= ST_IDLE;
					else if (act_q == ACT_FWD) state_q <= ST_ABS;
					else                       state_q <= ST_MUL2;
				end
				ST_ABS:  state_q <= ST_TIDX;
				ST_TIDX: state_q <= ST_TROM;
				ST_TROM: state_q <= ST_FIN;
				ST_MUL2: state_q <= (act_q == ACT_UPD) ? ST_DLT : ST_FIN;
				ST_DLT:  state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// architectural state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q        <= LEARN_RATE_RST;
			mo_q        <= MOMENTUM_RST;
			acc_q       <= '0;
			out_act_q   <= '0;
			grad_q      <= '0;
			sq_q        <= '0;
			vld_bits_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_LEARN_RATE) begin
					lr_q <= cfg_data;
				end else begin
					mo_q <= cfg_data;
				end
			end
			sq_q <= out_act_q * out_act_q;
			if (mem_we) begin
				vld_bits_q[mem_waddr] <= 1'b1;
			end
			if (state_q == ST_ACC) begin
				acc_q <= acc_q + ACC_W'(p1_s1);
			end
			if (fin_go) begin
				if (act_q == ACT_FWD) begin
					out_act_q <= fin_val;
					acc_q     <= '0;
				end
				if (act_q == ACT_HID) begin
					acc_q <= '0;
				end
				if (act_q == ACT_OGR || act_q == ACT_HID) begin
					grad_q <= fin_val;
				end
			end
			if (fin_go) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= act_in;
			ok_q   <= ok_in;
			last_q <= item.last;
			a_q    <= item.value_a;
			b_q    <= item.value_b;
			addr_q <= item_addr;
			vld_q  <= vld_bits_q[item_addr];
		end
		if (state_q == ST_MUL1) begin
			unique case (act_q)
				ACT_FWD: p1_s1 <= 37'(prod_aw);
				ACT_HID: p1_s1 <= 37'(prod_ab);
				ACT_OGR: p1_s1 <= prod_og;
				ACT_UPD: p1_s1 <= 37'(prod_ag);
				default: p1_s1 <= '0;
			endcase
			p2_s1 <= prod_mo;
		end
		if (state_q == ST_MUL2) begin
			pl_s2 <= acc_lo * deriv;
			ph_s2 <= acc_hi * deriv;
			p3_s2 <= lr_s * signed'(p1_s1[31:0]);
		end
		if (state_q == ST_ABS) begin
			mag_q <= acc_mag[26:0];
			hi_q  <= |acc_mag[ACC_W-1:27];
			neg_q <= acc_q[ACC_W-1];
		end
		if (state_q == ST_TIDX) begin
			tidx_q <= tidx_full[TAW-1:0];
			big_q  <= hi_q || (tidx_full >= (TAW+2)'(TANH_TABLE_DEPTH));
		end
		if (state_q == ST_DLT) begin
			delta_q <= s_dlt.val;
			dclip_q <= s_dlt.clip;
		end
		if (fin_go) begin
			res_val_q  <= fin_val;
			res_kind_q <= fin_kind;
			res_sat_q  <= fin_sat;
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !fin_go) |=> (state_q == ST_FIN))
		else $error("final step left while output register busy");

	a_mem_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE || state_q == ST_FIN))
		else $error("RAM write outside load or update commit");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && (act_q == ACT_FWD || act_q == ACT_HID)) |=> (acc_q == '0))
		else $error("accumulator not cleared after run end");

	a_act_unclipped: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.result_kind == KIND_ACT) |-> !result.saturated)
		else $error("activation result flagged saturated");

endmodule

### sim/tnb_checker.sv
// Scoreboard for the tanh neuron unit: predicts each result from accepted items and compares.
module tnb_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	tnb_in_if                             item,
	tnb_out_if                            result,
	input  logic                          cfg_we,
	input  logic [tnb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tnb_pkg::CFG_W-1:0]     cfg_data,
	output int                            errors,
	output int                            pending,
	output int                            checked
);
	import tnb_pkg::*;

	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	typedef struct {
		logic signed [VAL_W-1:0] val;
		logic [KIND_W-1:0]       kind;
		logic                    clip;
	} neuron_result_t;

	neuron_result_t          expected_q[$];
	int                      tanh_tab[TANH_DEPTH_DEF];
	logic signed [VAL_W-1:0] weights[INPUT_COUNT_DEF];
	logic signed [VAL_W-1:0] prev_delta[INPUT_COUNT_DEF];
	logic signed [ACC_W-1:0] acc;
	logic signed [VAL_W-1:0] out_act;
	logic signed [VAL_W-1:0] grad;
	logic [CFG_W-1:0]        eta;
	logic [CFG_W-1:0]        alpha;

	// same integer series as the hardware table: t = e^(-2x) stepped by repeated multiply
	function automatic void build_tanh();
		longint unsigned h, term, t, r;
		h = (64'd16 << 30) / TANH_DEPTH_DEF;
		r = ONE_Q30;
		term = ONE_Q30;
		t = ONE_Q30;
		for (int n = 1; n <= 10; n++) begin
			term = ((term * h) >> 30) / n;
			if (n % 2) r = r - term;
			else r = r + term;
		end
		for (int k = 0; k < TANH_DEPTH_DEF; k++) begin
			tanh_tab[k] = int'(((ONE_Q30 - t) * 8192 + (ONE_Q30 + t)) / (2 * (ONE_Q30 + t)));
			t = (t * r + (ONE_Q30 >> 1)) >> 30;
		end
	endfunction

	// round to nearest, ties toward plus infinity
	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [VAL_W-1:0] clip_q312(longint v, inout logic c);
		if (v > 32767) begin
			c = 1'b1;
			return 16'sh7fff;
		end
		if (v < -32768) begin
			c = 1'b1;
			return -16'sh8000;
		end
		return v[VAL_W-1:0];
	endfunction

	function automatic longint tanh_of(longint sum);
		longint unsigned m, idx;
		longint y;
		m = sum < 0 ? -sum : sum;
		idx = (m * TANH_DEPTH_DEF + (64'd1 << 26)) >> 27;
		y = idx >= TANH_DEPTH_DEF ? 64'sd4096 : longint'(tanh_tab[idx]);
		return sum < 0 ? -y : y;
	endfunction

	function automatic longint slope();
		longint o;
		o = longint'(out_act);
		return 4096 - round_shift(o * o, 12);
	endfunction

	function automatic void model_reset();
		foreach (weights[i]) begin
			weights[i] = '0;
			prev_delta[i] = '0;
		end
		acc = '0;
		out_act = '0;
		grad = '0;
		eta = LEARN_RATE_RST;
		alpha = MOMENTUM_RST;
		expected_q.delete();
	endfunction

	function automatic void predict(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
			logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b, logic last);
		neuron_result_t r;
		longint p, sum, delta;
		logic c;
		c = 1'b0;
		case (action_t'(act))
			ACT_LOAD: begin
				weights[idx] = a;
				prev_delta[idx] = '0;
			end
			ACT_FWD: begin
				p = longint'(a) * longint'(weights[idx]);
				acc = acc + p[ACC_W-1:0];
				if (last) begin
					r.val = VAL_W'(tanh_of(longint'(acc)));
					r.kind = KIND_ACT;
					r.clip = 1'b0;
					acc = '0;
					out_act = r.val;
					expected_q.insert(expected_q.size(), r);
				end
			end
			ACT_OGR: begin
				r.val = clip_q312(round_shift((longint'(a) - longint'(out_act)) * slope(), 12), c);
				r.kind = KIND_GRAD;
				r.clip = c;
				grad = r.val;
				expected_q.insert(expected_q.size(), r);
			end
			ACT_HID: begin
				p = longint'(a) * longint'(b);
				acc = acc + p[ACC_W-1:0];
				if (last) begin
					r.val = clip_q312(round_shift(longint'(acc) * slope(), 24), c);
					r.kind = KIND_GRAD;
					r.clip = c;
					acc = '0;
					grad = r.val;
					expected_q.insert(expected_q.size(), r);
				end
			end
			ACT_UPD: begin
				sum = longint'(eta) * longint'(a) * longint'(grad)
					+ longint'(alpha) * longint'(prev_delta[idx]) * 4096;
				delta = longint'(clip_q312(round_shift(sum, 24), c));
				prev_delta[idx] = delta[VAL_W-1:0];
				r.val = clip_q312(longint'(weights[idx]) + delta, c);
				r.kind = KIND_WGT;
				r.clip = c;
				weights[idx] = r.val;
				expected_q.insert(expected_q.size(), r);
			end
			default: ;
		endcase
	endfunction

	initial begin
		build_tanh();
		model_reset();
		errors = 0;
		pending = 0;
		checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		neuron_result_t e;
		if (!arst_n) begin
			model_reset();
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_LEARN_RATE) eta = cfg_data;
				else if (cfg_index == CFG_MOMENTUM) alpha = cfg_data;
			end
			if (item.valid && item.ready)
				predict(item.action, item.element_index, item.value_a, item.value_b, item.last);
			if (result.valid && result.ready) begin
				checked++;
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result value %0d kind %0d sat %0b", $time,
						result.result_value, result.result_kind, result.saturated);
				end else begin
					e = expected_q.pop_front();
					if (result.result_value !== e.val) begin
						errors++;
						$display("%0t: result_value expected %0d actual %0d", $time, e.val,
							result.result_value);
					end
					if (result.result_kind !== e.kind) begin
						errors++;
						$display("%0t: result_kind expected %0d actual %0d", $time, e.kind,
							result.result_kind);
					end
					if (result.saturated !== e.clip) begin
						errors++;
						$display("%0t: saturated expected %0b actual %0b", $time, e.clip,
							result.saturated);
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

### sim/tanh_neuron_backprop_unit_tb.sv
// Stimulus, handshake pacing and verdict for the tanh neuron training unit.
module tanh_neuron_backprop_unit_tb;
	import tnb_pkg::*;

	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   errors;
	int                   pending;
	int                   checked;
	int                   items_sent;
	int                   settings_used;
	bit                   long_hold;
	bit                   rx_eager;

	tnb_in_if  in_ch();
	tnb_out_if out_ch();

	tanh_neuron_backprop_unit dut (
		.clk(clk), .arst_n(arst_n), .item(in_ch), .result(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tnb_checker scoreboard (
		.clk(clk), .arst_n(arst_n), .item(in_ch), .result(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Q3.12 operand: near the active tanh range as often as full range, some corners
	function automatic logic signed [VAL_W-1:0] pick_q312();
		case ($urandom_range(0, 4))
			0: return VAL_W'($urandom);
			1: return VAL_W'($urandom_range(0, 8192) - 4096);
			2: return VAL_W'($urandom_range(0, 2048) - 1024);
			3: return VAL_W'($urandom_range(0, 65535));
			default: case ($urandom_range(0, 3))
				0: return 16'sh7fff;
				1: return -16'sh8000;
				2: return 16'sd4096;
				default: return 16'sd0;
			endcase
		endcase
	endfunction

	task automatic send(action_t act, int idx, logic signed [VAL_W-1:0] a,
			logic signed [VAL_W-1:0] b, logic last);
		int gap;
		gap = rx_eager ? 0 : $urandom_range(0, 9);
		repeat (gap) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.element_index <= idx[IDX_W-1:0];
		in_ch.value_a <= a;
		in_ch.value_b <= b;
		in_ch.last <= last;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	// wait until every expected result is back, then let a result-less item finish
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_rates(logic [CFG_W-1:0] lr, logic [CFG_W-1:0] mom);
		settle();
		write_cfg(CFG_LEARN_RATE, lr);
		write_cfg(CFG_MOMENTUM, mom);
		settings_used++;
	endtask

	task automatic random_phase(int count);
		int stop, len;
		stop = items_sent + count;
		while (items_sent < stop) begin
			case ($urandom_range(0, 9))
				0: send(action_t'(ACT_W'($urandom_range(0, 7))), $urandom_range(0, 15),
					VAL_W'($urandom), VAL_W'($urandom), 1'($urandom_range(0, 1)));
				1, 2: repeat ($urandom_range(1, 4))
					send(ACT_LOAD, $urandom_range(0, 15), pick_q312(), VAL_W'($urandom),
						1'($urandom));
				3, 4: begin
					len = $urandom_range(1, 16);
					for (int i = 0; i < len; i++)
						send(ACT_FWD, $urandom_range(0, 15), pick_q312(), VAL_W'($urandom),
							i == len - 1);
				end
				5: send(ACT_OGR, $urandom, pick_q312(), VAL_W'($urandom), 1'($urandom));
				6: begin
					len = $urandom_range(1, 8);
					for (int i = 0; i < len; i++)
						send(ACT_HID, $urandom, pick_q312(), pick_q312(), i == len - 1);
				end
				default: repeat ($urandom_range(1, 4))
					send(ACT_UPD, $urandom_range(0, 15), pick_q312(), VAL_W'($urandom),
						1'($urandom));
			endcase
		end
	endtask

	// result side: random stalls, eager stretches, one long hold-off on request
	initial begin
		int gap;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end
			gap = rx_eager ? 0 : $urandom_range(0, 9);
			repeat (gap) begin
				out_ch.ready <= 1'b0;
				@(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
			else quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("tanh_neuron_backprop_unit test failed");
				$finish;
			end
		end
	end

	initial begin
		items_sent = 0;
		settings_used = 0;
		long_hold = 1'b0;
		rx_eager = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_LEARN_RATE;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.action <= ACT_LOAD;
		in_ch.element_index <= '0;
		in_ch.value_a <= '0;
		in_ch.value_b <= '0;
		in_ch.last <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset rates, extreme operands, every action, unknown codes
		send(ACT_FWD, 3, 16'sh7fff, '0, 1'b1);
		send(ACT_LOAD, 0, 16'sh7fff, '0, 1'b0);
		send(ACT_LOAD, 15, -16'sh8000, 16'sh7fff, 1'b1);
		send(ACT_LOAD, 5, 16'sd4096, '0, 1'b0);
		send(ACT_FWD, 0, 16'sh7fff, '0, 1'b0);
		send(ACT_FWD, 15, -16'sh8000, '0, 1'b0);
		send(ACT_FWD, 5, 16'sd2048, -16'sh8000, 1'b1);
		send(ACT_OGR, 0, 16'sh7fff, '0, 1'b0);
		send(ACT_OGR, 0, -16'sh8000, '0, 1'b0);
		send(ACT_UPD, 0, 16'sh7fff, '0, 1'b0);
		send(ACT_UPD, 0, 16'sh7fff, '0, 1'b0);
		send(ACT_UPD, 15, -16'sh8000, '0, 1'b1);
		send(ACT_HID, 0, -16'sh8000, -16'sh8000, 1'b0);
		send(ACT_HID, 0, -16'sh8000, -16'sh8000, 1'b1);
		send(ACT_HID, 0, 16'sh7fff, -16'sh8000, 1'b1);
		send(ACT_UPD, 5, -16'sh8000, '0, 1'b0);
		send(action_t'(3'd5), 1, 16'sh1234, 16'sh4321, 1'b1);
		send(action_t'(3'd6), 2, -16'sh8000, 16'sh7fff, 1'b0);
		send(action_t'(3'd7), 15, 16'sh7fff, -16'sh8000, 1'b1);
		send(ACT_FWD, 7, 16'sd100, '0, 1'b1);
		send(ACT_OGR, 7, 16'sd0, '0, 1'b0);
		settings_used++;

		random_phase(130);
		set_rates(13'd0, 13'd0);
		long_hold = 1'b1;
		random_phase(110);
		set_rates(13'd4096, 13'd4096);
		rx_eager = 1'b1;
		random_phase(90);
		rx_eager = 1'b0;
		random_phase(40);
		set_rates(13'd8191, 13'd8191);
		random_phase(90);
		set_rates(13'd1, 13'd4095);
		random_phase(90);
		set_rates(LEARN_RATE_RST, MOMENTUM_RST);
		random_phase(90);
		settle();

		$display("Sent %0d items over %0d rate settings; %0d results compared.",
			items_sent, settings_used, checked);
		$display("Mix: loads, forward and hidden runs, output gradients, updates, unknown codes.");
		if (errors == 0) $display("tanh_neuron_backprop_unit test passed");
		else $display("tanh_neuron_backprop_unit test failed");
		$finish;
	end

endmodule
